// ===== rtl/edh_pkg.sv =====
// shared widths and limits of the earliest-deadline heap scheduler
package edh_pkg;

  localparam int unsigned CNT_W     = 9;
  localparam int unsigned OUT_DAY_W = 16;
  localparam int unsigned ATT_W     = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [ATT_W-1:0] ATT_MAX = '1;

endpackage

// ===== rtl/edh_in_if.sv =====
// input channel: push or day tick items
interface edh_in_if #(
  parameter int unsigned DAY_BITS = 16
);
  logic                valid;
  logic                ready;
  logic                mode;
  logic [DAY_BITS-1:0] deadline;
  logic [DAY_BITS-1:0] day;

  modport source (output valid, mode, deadline, day, input ready);
  modport sink   (input valid, mode, deadline, day, output ready);
endinterface

// ===== rtl/edh_out_if.sv =====
// output channel: one result per input item
interface edh_out_if
  import edh_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 served;
  logic [OUT_DAY_W-1:0] served_deadline;
  logic [CNT_W-1:0]     expired_count;
  logic [ATT_W-1:0]     attended_total;
  logic                 overflow;
  logic [CNT_W-1:0]     occupancy;

  modport source (output valid, served, served_deadline, expired_count, attended_total,
                  overflow, occupancy, input ready);
  modport sink   (input valid, served, served_deadline, expired_count, attended_total,
                  overflow, occupancy, output ready);
endinterface

// ===== rtl/edh_ram.sv =====
// generic single-write single-read ram with registered read data
module edh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/earliest_deadline_min_heap_scheduler.sv =====
// earliest-deadline scheduler: binary min-heap of deadlines held in one ram
// push: the new deadline enters at the end and climbs past larger parents; when full it is dropped with overflow
// tick: roots before the day expire and are removed, then any remaining root is served; each removal sifts down
// removing the only entry skips the last-entry load and the sift; ram latency sets the pace
// one item in flight; next item taken once the result sits in the output register
// async active-low reset empties the heap and clears the attended count; ram is not cleared
module earliest_deadline_min_heap_scheduler
  import edh_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 256,
  parameter int unsigned DAY_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  edh_in_if.sink       in_i,
  edh_out_if.source    out_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned SW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ROOT, S_LAST, S_DL, S_DR, S_DC, S_UP, S_UW, S_DONE
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       count_q;
  logic [ATT_W-1:0]    att_q;
  logic [AW-1:0]       hole_q;
  logic [AW-1:0]       par_q;
  logic [DAY_BITS-1:0] val_q;
  logic [DAY_BITS-1:0] lval_q;
  logic [DAY_BITS-1:0] day_q;
  logic                served_q;
  logic [DAY_BITS-1:0] sdl_q;
  logic [CW-1:0]       exp_q;
  logic                ovf_q;
  logic                final_q;

  logic                 ov_q;
  logic                 o_served_q;
  logic [OUT_DAY_W-1:0] o_sdl_q;
  logic [CNT_W-1:0]     o_exp_q;
  logic [ATT_W-1:0]     o_att_q;
  logic                 o_ovf_q;
  logic [CNT_W-1:0]     o_occ_q;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [DAY_BITS-1:0] wdata;
  logic [AW-1:0]       raddr;
  logic [DAY_BITS-1:0] rdata;

  logic [LW-1:0]       left_w;
  logic [LW-1:0]       right_w;
  logic [LW-1:0]       cnt_ext;
  logic                left_in;
  logic                right_in;
  logic [AW-1:0]       parent;
  logic                c_right;
  logic [DAY_BITS-1:0] cval;
  logic [AW-1:0]       cidx;
  logic                load_out;
  logic [SW-1:0]       exp_ext;
  logic [SW-1:0]       occ_ext;
  logic [CNT_W-1:0]    exp_sat;
  logic [CNT_W-1:0]    occ_sat;
  state_e              after_sift;

  edh_ram #(
    .WIDTH(DAY_BITS),
    .DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign left_w     = {hole_q, 1'b1};
  assign right_w    = left_w + LW'(1);
  assign cnt_ext    = LW'(count_q);
  assign left_in    = left_w < cnt_ext;
  assign right_in   = right_w < cnt_ext;
  assign parent     = AW'((hole_q - AW'(1)) >> 1);
  assign c_right    = rdata < lval_q;
  assign cval       = c_right ? rdata : lval_q;
  assign cidx       = c_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign after_sift = final_q ? S_DONE : S_CHECK;
  assign load_out   = (state_q == S_DONE) && (!ov_q || out_o.ready);

  assign exp_ext = SW'(exp_q);
  assign occ_ext = SW'(count_q);
  assign exp_sat = (exp_ext > SW'(CNT_MAX)) ? CNT_MAX : exp_ext[CNT_W-1:0];
  assign occ_sat = (occ_ext > SW'(CNT_MAX)) ? CNT_MAX : occ_ext[CNT_W-1:0];

  // ram port control
  always_comb begin
    we    = 1'b0;
    waddr = hole_q;
    wdata = val_q;
    raddr = '0;
    unique case (state_q)
      S_ROOT: raddr = AW'(count_q - CW'(1));
      S_DL: begin
        raddr = left_w[AW-1:0];
        we    = !left_in;
      end
      S_DR: begin
        raddr = right_w[AW-1:0];
        if (!right_in) begin
          we    = 1'b1;
          wdata = (rdata < val_q) ? rdata : val_q;
        end
      end
      S_DC: begin
        we    = 1'b1;
        wdata = (cval < val_q) ? cval : val_q;
      end
      S_UP: begin
        if (hole_q == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      S_UW: begin
        we    = 1'b1;
        wdata = (val_q < rdata) ? rdata : val_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      att_q      <= '0;
      hole_q     <= '0;
      par_q      <= '0;
      val_q      <= '0;
      lval_q     <= '0;
      day_q      <= '0;
      served_q   <= 1'b0;
      sdl_q      <= '0;
      exp_q      <= '0;
      ovf_q      <= 1'b0;
      final_q    <= 1'b0;
      ov_q       <= 1'b0;
      o_served_q <= 1'b0;
      o_sdl_q    <= '0;
      o_exp_q    <= '0;
      o_att_q    <= '0;
      o_ovf_q    <= 1'b0;
      o_occ_q    <= '0;
    end else begin
      if (load_out) begin
        ov_q       <= 1'b1;
        o_served_q <= served_q;
        o_sdl_q    <= OUT_DAY_W'(sdl_q);
        o_exp_q    <= exp_sat;
        o_att_q    <= att_q;
        o_ovf_q    <= ovf_q;
        o_occ_q    <= occ_sat;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            served_q <= 1'b0;
            sdl_q    <= '0;
            exp_q    <= '0;
            ovf_q    <= 1'b0;
            if (!in_i.mode) begin
              if (count_q == CW'(HEAP_DEPTH)) begin
                ovf_q   <= 1'b1;
                state_q <= S_DONE;
              end else begin
                val_q   <= in_i.deadline;
                hole_q  <= AW'(count_q);
                count_q <= count_q + CW'(1);
                state_q <= S_UP;
              end
            end else begin
              day_q   <= in_i.day;
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: state_q <= (count_q == '0) ? S_DONE : S_ROOT;
        S_ROOT: begin
          count_q <= count_q - CW'(1);
          if (rdata < day_q) begin
            exp_q   <= exp_q + CW'(1);
            final_q <= 1'b0;
            state_q <= (count_q == CW'(1)) ? S_CHECK : S_LAST;
          end else begin
            served_q <= 1'b1;
            sdl_q    <= rdata;
            if (att_q != ATT_MAX) begin
              att_q <= att_q + ATT_W'(1);
            end
            final_q <= 1'b1;
            state_q <= (count_q == CW'(1)) ? S_DONE : S_LAST;
          end
        end
        S_LAST: begin
          val_q   <= rdata;
          hole_q  <= '0;
          state_q <= S_DL;
        end
        S_DL: begin
          if (!left_in) begin
            state_q <= after_sift;
          end else begin
            state_q <= S_DR;
          end
        end
        S_DR: begin
          lval_q <= rdata;
          if (right_in) begin
            state_q <= S_DC;
          end else if (rdata < val_q) begin
            hole_q  <= left_w[AW-1:0];
            state_q <= S_DL;
          end else begin
            state_q <= after_sift;
          end
        end
        S_DC: begin
          if (cval < val_q) begin
            hole_q  <= cidx;
            state_q <= S_DL;
          end else begin
            state_q <= after_sift;
          end
        end
        S_UP: begin
          if (hole_q == '0) begin
            state_q <= S_DONE;
          end else begin
            par_q   <= parent;
            state_q <= S_UW;
          end
        end
        S_UW: begin
          if (val_q < rdata) begin
            hole_q  <= par_q;
            state_q <= S_UP;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = ov_q;
  assign out_o.served          = o_served_q;
  assign out_o.served_deadline = o_sdl_q;
  assign out_o.expired_count   = o_exp_q;
  assign out_o.attended_total  = o_att_q;
  assign out_o.overflow        = o_ovf_q;
  assign out_o.occupancy       = o_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_ovf_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |-> (!out_o.served && out_o.expired_count == '0))
    else $error("dropped push reports tick results");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != S_IDLE))
    else $error("transfer taken without starting work");

  a_hole_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DL || state_q == S_DR || state_q == S_DC) |-> (LW'(hole_q) < cnt_ext))
    else $error("sift position outside heap");

endmodule
